/* design/frls_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// frls_pkg: shared types and constants of the flash record log store
// Flash geometry, header layout, request and status codes, and the
// transaction structs of the request and result channels.
// ----------------------------------------------------------------------------
package frls_pkg;

	// Flash geometry
	localparam int FLASH_WORDS = 4096;
	localparam int ADDR_W      = $clog2(FLASH_WORDS);
	localparam int CUR_W       = ADDR_W + 1;

	// Header layout: name in the low bits, byte size above
	localparam int NAME_BITS = 20;
	localparam int SIZE_W    = 32 - NAME_BITS;
	localparam logic [NAME_BITS-1:0] NMAX    = {NAME_BITS{1'b1}};
	localparam logic [SIZE_W-1:0]    LEN_MAX = {SIZE_W{1'b1}};

	// Request codes
	localparam logic [2:0] REQ_FIND_LATEST = 3'd0;
	localparam logic [2:0] REQ_FIND_FIRST  = 3'd1;
	localparam logic [2:0] REQ_APPEND      = 3'd2;
	localparam logic [2:0] REQ_PROGRAM     = 3'd3;
	localparam logic [2:0] REQ_ERASE       = 3'd4;
	localparam logic [2:0] REQ_READ        = 3'd5;

	// Status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND  = 3'd1;
	localparam logic [2:0] ST_INVALID    = 3'd2;
	localparam logic [2:0] ST_NO_END     = 3'd3;
	localparam logic [2:0] ST_NO_SPACE   = 3'd4;
	localparam logic [2:0] ST_BAD_TARGET = 3'd5;
	localparam logic [2:0] ST_NO_PENDING = 3'd6;

	// Request transaction
	typedef struct packed {
		logic [2:0]  req_type;
		logic [19:0] name;
		logic [12:0] start_offset;
		logic [11:0] length;
		logic [31:0] data_word;
		logic [11:0] word_index;
	} req_t;

	// Result transaction
	typedef struct packed {
		logic [2:0]  status;
		logic [11:0] record_index;
		logic [11:0] size_bytes;
		logic [12:0] next_offset;
		logic [31:0] read_data;
	} rsp_t;

endpackage
`default_nettype wire

/* design/flash_record_log_store_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// flash_record_log_store_top: record log store on an erased-to-ones flash
// Serves find, append, program, erase and read requests on a 4096-word
// flash memory through one read port and one write port under a sequencer.
// ----------------------------------------------------------------------------
// After reset the block sweeps the flash to all ones, one word a cycle, and
// holds busy high for the whole sweep. A request is taken when start is
// high and busy is low; every request returns exactly one result, shown for
// one cycle with done high, and the receiver cannot stall it. A request that
// fails its input checks answers in the cycle after it is taken. Program
// and erase read the word, modify it and answer; read reads the word and answers.
// Find and append walk the record headers through the single memory read
// port, fetching and then evaluating each header in turn, up to and including
// the erased end header. busy drops in the cycle that done rises, so a new
// request may be taken while a result is shown.
module flash_record_log_store_top (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            start,
	input  frls_pkg::req_t req,
	output logic           busy,
	output logic           done,
	output frls_pkg::rsp_t rsp
);
	import frls_pkg::*;

	typedef enum logic [6:0] {
		S_CLEAR   = 7'b0000001,
		S_IDLE    = 7'b0000010,
		S_SCAN_RD = 7'b0000100,
		S_SCAN_EV = 7'b0001000,
		S_SCAN_END= 7'b0010000,
		S_MEM_RD  = 7'b0100000,
		S_MEM_EV  = 7'b1000000
	} state_t;

	state_t state_q;

	// Flash array and its ports
	logic [31:0]       mem [FLASH_WORDS];
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [31:0]       wdata;
	logic [ADDR_W-1:0] raddr;
	logic [31:0]       rdata_q;

	// Sequencer registers
	logic [ADDR_W-1:0]    clr_q;
	logic [2:0]           op_q;
	logic [NAME_BITS-1:0] name_q;
	logic [NAME_BITS-1:0] target_q;
	logic [SIZE_W-1:0]    len_q;
	logic [31:0]          dw_q;
	logic [ADDR_W-1:0]    wi_q;
	logic                 first_q;
	logic [CUR_W-1:0]     p_q;
	logic                 hit_q;
	logic [ADDR_W-1:0]    hdr_q;
	logic [SIZE_W-1:0]    sz_q;
	logic [CUR_W-1:0]     cursor_q;
	logic [10:0]          pend_q;
	logic                 done_q;
	rsp_t                 rsp_q;

	// Decode of the incoming request
	logic             in_name_ok;
	logic [CUR_W-1:0] in_start;
	logic [CUR_W-1:0] in_start_clamp;
	assign in_name_ok = (req.name != '0) && (req.name != NMAX);
	assign in_start = (req.req_type == REQ_FIND_FIRST) ? req.start_offset : '0;
	assign in_start_clamp = (in_start > CUR_W'(FLASH_WORDS)) ? CUR_W'(FLASH_WORDS) : in_start;

	// Header walk: next cursor, saturated at the flash end
	logic [NAME_BITS-1:0] hdr_name;
	logic [SIZE_W-1:0]    hdr_size;
	logic [CUR_W:0]       skip;
	logic [CUR_W-1:0]     p_next;
	logic                 hdr_match;
	assign hdr_name  = rdata_q[NAME_BITS-1:0];
	assign hdr_size  = rdata_q[31:NAME_BITS];
	assign skip      = {1'b0, p_q} + (CUR_W+1)'(1)
		+ (CUR_W+1)'(({2'b00, hdr_size} + (SIZE_W+2)'(3)) >> 2);
	assign p_next    = (skip > (CUR_W+1)'(FLASH_WORDS)) ? CUR_W'(FLASH_WORDS)
		: skip[CUR_W-1:0];
	assign hdr_match = (hdr_name == target_q);

	// Append space check in words
	logic [SIZE_W:0]  len_p3;
	logic [10:0]      need_words;
	logic [CUR_W-1:0] free_words;
	logic             append_ok;
	logic [CUR_W-1:0] p_clamp;
	assign len_p3     = {1'b0, len_q} + (SIZE_W+1)'(3);
	assign need_words = len_p3[SIZE_W:2];
	assign free_words = CUR_W'(FLASH_WORDS - 1) - {1'b0, hdr_q};
	assign append_ok  = hit_q && (sz_q == LEN_MAX)
		&& (free_words >= CUR_W'(need_words));
	assign p_clamp    = (p_q > CUR_W'(FLASH_WORDS)) ? CUR_W'(FLASH_WORDS) : p_q;

	// Erase target check against the word just read
	logic erase_ok;
	assign erase_ok = (rdata_q[NAME_BITS-1:0] == name_q);

	// Drive the memory ports
	always_comb begin
		we    = 1'b0;
		waddr = clr_q;
		wdata = '1;
		raddr = p_q[ADDR_W-1:0];
		case (state_q)
			S_CLEAR: begin
				we = 1'b1;
			end
			S_SCAN_END: begin
				we    = (op_q == REQ_APPEND) && append_ok;
				waddr = hdr_q;
				wdata = {len_q, name_q};
			end
			S_MEM_RD: begin
				raddr = (op_q == REQ_PROGRAM) ? cursor_q[ADDR_W-1:0] : wi_q;
			end
			S_MEM_EV: begin
				if (op_q == REQ_PROGRAM) begin
					we    = 1'b1;
					waddr = cursor_q[ADDR_W-1:0];
					wdata = rdata_q & dw_q;
				end else if (op_q == REQ_ERASE) begin
					we    = erase_ok;
					waddr = wi_q;
					wdata = {rdata_q[31:NAME_BITS], {NAME_BITS{1'b0}}};
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// Flash array: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// Transaction payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q     <= req.req_type;
			name_q   <= req.name;
			len_q    <= req.length;
			dw_q     <= req.data_word;
			wi_q     <= req.word_index;
			first_q  <= (req.req_type == REQ_FIND_FIRST);
			target_q <= (req.req_type == REQ_APPEND) ? NMAX : req.name;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			cursor_q <= '0;
			pend_q   <= '0;
			p_q      <= '0;
			hit_q    <= 1'b0;
			hdr_q    <= '0;
			sz_q     <= '0;
			done_q   <= 1'b0;
			rsp_q    <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				// Sweep the flash to the erased state
				S_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(FLASH_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				// Take a request; answer failed checks at once
				S_IDLE: begin
					if (start) begin
						rsp_q <= '0;
						hit_q <= 1'b0;
						case (req.req_type)
							REQ_FIND_LATEST, REQ_FIND_FIRST: begin
								if (!in_name_ok) begin
									done_q            <= 1'b1;
									rsp_q.status      <= ST_INVALID;
									rsp_q.next_offset <= in_start_clamp;
								end else begin
									p_q     <= in_start;
									state_q <= S_SCAN_RD;
								end
							end
							REQ_APPEND: begin
								if (!in_name_ok || req.length == LEN_MAX) begin
									done_q       <= 1'b1;
									rsp_q.status <= ST_INVALID;
								end else begin
									p_q     <= '0;
									state_q <= S_SCAN_RD;
								end
							end
							REQ_PROGRAM: begin
								if (pend_q == '0 || cursor_q >= CUR_W'(FLASH_WORDS)) begin
									done_q            <= 1'b1;
									rsp_q.status      <= ST_NO_PENDING;
									rsp_q.next_offset <= cursor_q;
								end else begin
									state_q <= S_MEM_RD;
								end
							end
							REQ_ERASE: begin
								if (!in_name_ok) begin
									done_q       <= 1'b1;
									rsp_q.status <= ST_INVALID;
								end else if ({1'b0, req.word_index}
									>= CUR_W'(FLASH_WORDS - 1)) begin
									done_q       <= 1'b1;
									rsp_q.status <= ST_BAD_TARGET;
								end else begin
									state_q <= S_MEM_RD;
								end
							end
							REQ_READ: begin
								state_q <= S_MEM_RD;
							end
							default: begin
								done_q       <= 1'b1;
								rsp_q.status <= ST_INVALID;
							end
						endcase
					end
				end
				// Fetch the header at the cursor, or stop at the flash end
				S_SCAN_RD: begin
					if (p_q >= CUR_W'(FLASH_WORDS)) begin
						state_q <= S_SCAN_END;
					end else begin
						state_q <= S_SCAN_EV;
					end
				end
				// Record a match and advance past the record
				S_SCAN_EV: begin
					p_q <= p_next;
					if (hdr_match) begin
						hit_q <= 1'b1;
						hdr_q <= p_q[ADDR_W-1:0];
						sz_q  <= hdr_size;
					end
					if ((hdr_match && first_q) || hdr_name == NMAX) begin
						state_q <= S_SCAN_END;
					end else begin
						state_q <= S_SCAN_RD;
					end
				end
				// Finish a find or an append
				S_SCAN_END: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if (op_q == REQ_APPEND) begin
						if (!hit_q || sz_q != LEN_MAX) begin
							rsp_q.status <= ST_NO_END;
						end else if (!append_ok) begin
							rsp_q.status <= ST_NO_SPACE;
						end else begin
							cursor_q           <= {1'b0, hdr_q} + CUR_W'(1);
							pend_q             <= need_words;
							rsp_q.record_index <= hdr_q;
							rsp_q.size_bytes   <= len_q;
							rsp_q.next_offset  <= {1'b0, hdr_q} + CUR_W'(1);
						end
					end else begin
						rsp_q.next_offset <= p_clamp;
						if (hit_q) begin
							rsp_q.record_index <= hdr_q;
							rsp_q.size_bytes   <= sz_q;
						end else begin
							rsp_q.status <= ST_NOT_FOUND;
						end
					end
				end
				// Wait for the word under modify
				S_MEM_RD: begin
					state_q <= S_MEM_EV;
				end
				// Write back the modified word for program or erase, and answer
				S_MEM_EV: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					case (op_q)
						REQ_PROGRAM: begin
							cursor_q          <= cursor_q + CUR_W'(1);
							pend_q            <= pend_q - 11'd1;
							rsp_q.next_offset <= cursor_q + CUR_W'(1);
						end
						REQ_ERASE: begin
							if (erase_ok) begin
								rsp_q.record_index <= wi_q;
							end else begin
								rsp_q.status <= ST_BAD_TARGET;
							end
						end
						default: begin
							rsp_q.read_data <= rdata_q;
						end
					endcase
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// Hold busy through the clearing sweep
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> busy)
		else $error("busy low during clearing sweep");

	// Pending data never runs past the flash end
	a_pend_fits: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cursor_q} + (CUR_W+1)'(pend_q)) <= (CUR_W+1)'(FLASH_WORDS))
		else $error("pending data exceeds flash");

	// Keep the write port quiet while idle, fetching headers or fetching a word to modify
	a_no_stray_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_SCAN_RD || state_q == S_MEM_RD) |-> !we)
		else $error("unexpected flash write");

	// Advance the scan cursor on every header
	a_scan_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN_EV) |=> (p_q > $past(p_q)))
		else $error("scan cursor did not advance");

endmodule
`default_nettype wire

/* tb/flash_record_log_store_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_record_log_store_top_tb: self-checking bench of the record log store
// Drives find, append, program, erase and read transactions through the
// start/busy handshake. A software copy of the flash log predicts every
// result, and each done strobe is compared field by field with the oldest
// prediction. The run starts on an empty log and ends with the log full.
// ----------------------------------------------------------------------------

import frls_pkg::*;

// Predict results from a private copy of the flash log and check the strobes
class record_log_scoreboard;
	bit [31:0]   flash_copy [FLASH_WORDS];
	int unsigned write_ptr;
	int unsigned words_left;
	rsp_t        awaited [$];
	int          errors;

	function new();
		foreach (flash_copy[i]) flash_copy[i] = '1;
		write_ptr  = 0;
		words_left = 0;
		errors     = 0;
	endfunction

	function automatic bit name_valid(logic [NAME_BITS-1:0] nm);
		return nm != '0 && nm < NMAX;
	endfunction

	// Walk the headers from a cursor; return whether the target name was seen
	function automatic bit walk_headers(input logic [NAME_BITS-1:0] target,
			input int unsigned from, input bit stop_first,
			output int unsigned hdr, output int unsigned sz, output int unsigned endp);
		int unsigned           p;
		int unsigned           here;
		int unsigned           s;
		logic [NAME_BITS-1:0]  nm;
		bit                    hit;
		p   = from;
		hit = 1'b0;
		hdr = 0;
		sz  = 0;
		while (p < FLASH_WORDS) begin
			here = p;
			nm   = flash_copy[p][NAME_BITS-1:0];
			s    = 32'(flash_copy[p][31:NAME_BITS]);
			// skip the padded data; saturate at the end of flash
			p = p + 1 + (s + 3) / 4;
			if (p > FLASH_WORDS)
				p = FLASH_WORDS;
			if (nm == target) begin
				hit = 1'b1;
				hdr = here;
				sz  = s;
				if (stop_first)
					break;
			end
			if (nm == NMAX)
				break;
		end
		if (p > FLASH_WORDS)
			p = FLASH_WORDS;
		endp = p;
		return hit;
	endfunction

	// Compute the result of one request and update the log copy
	function automatic rsp_t predict_response(req_t r);
		rsp_t        o;
		int unsigned hdr;
		int unsigned sz;
		int unsigned endp;
		int unsigned from;
		int unsigned room;
		int unsigned padded;
		o    = '0;
		hdr  = 0;
		sz   = 0;
		endp = 0;
		case (r.req_type)
			REQ_FIND_LATEST, REQ_FIND_FIRST: begin
				from = (r.req_type == REQ_FIND_FIRST) ? int'(r.start_offset) : 0;
				if (!name_valid(r.name)) begin
					o.status      = ST_INVALID;
					o.next_offset = 13'((from > FLASH_WORDS) ? FLASH_WORDS : from);
				end else begin
					if (walk_headers(r.name, from, r.req_type == REQ_FIND_FIRST, hdr, sz,
							endp)) begin
						o.record_index = 12'(hdr);
						o.size_bytes   = 12'(sz);
					end else begin
						o.status = ST_NOT_FOUND;
					end
					o.next_offset = 13'(endp);
				end
			end
			REQ_APPEND: begin
				if (!name_valid(r.name) || r.length >= LEN_MAX) begin
					o.status = ST_INVALID;
				end else if (!walk_headers(NMAX, 0, 1'b0, hdr, sz, endp) || sz != LEN_MAX) begin
					o.status = ST_NO_END;
				end else begin
					room   = (FLASH_WORDS - (hdr + 1)) * 4;
					padded = (int'(r.length) + 3) & ~3;
					if (room < padded) begin
						o.status = ST_NO_SPACE;
					end else begin
						flash_copy[hdr] &= {r.length, r.name};
						write_ptr       = hdr + 1;
						words_left      = (int'(r.length) + 3) / 4;
						o.record_index  = 12'(hdr);
						o.size_bytes    = r.length;
						o.next_offset   = 13'(write_ptr);
					end
				end
			end
			REQ_PROGRAM: begin
				if (words_left == 0 || write_ptr >= FLASH_WORDS) begin
					o.status = ST_NO_PENDING;
				end else begin
					flash_copy[write_ptr] &= r.data_word;
					write_ptr++;
					words_left--;
				end
				o.next_offset = 13'(write_ptr);
			end
			REQ_ERASE: begin
				if (!name_valid(r.name)) begin
					o.status = ST_INVALID;
				end else if (r.word_index >= FLASH_WORDS - 1) begin
					o.status = ST_BAD_TARGET;
				end else if (flash_copy[r.word_index][NAME_BITS-1:0] != r.name) begin
					o.status = ST_BAD_TARGET;
				end else begin
					flash_copy[r.word_index][NAME_BITS-1:0] = '0;
					o.record_index = r.word_index;
				end
			end
			REQ_READ: begin
				if (r.word_index >= FLASH_WORDS)
					o.status = ST_BAD_TARGET;
				else
					o.read_data = flash_copy[r.word_index];
			end
			default: begin
				o.status = ST_INVALID;
			end
		endcase
		return o;
	endfunction

	// Note an accepted transaction; hand back its predicted result
	function automatic rsp_t note_request(req_t r);
		rsp_t p;
		p = predict_response(r);
		awaited.push_back(p);
		return p;
	endfunction

	function automatic void field_check(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
			errors++;
		end
	endfunction

	// Compare one result strobe with the oldest prediction
	function automatic void check_result(rsp_t got);
		rsp_t want;
		if (awaited.size() == 0) begin
			$error("result with no transaction outstanding: 0x%0h", got);
			errors++;
			return;
		end
		want = awaited.pop_front();
		field_check("status", 32'(want.status), 32'(got.status));
		field_check("record_index", 32'(want.record_index), 32'(got.record_index));
		field_check("size_bytes", 32'(want.size_bytes), 32'(got.size_bytes));
		field_check("next_offset", 32'(want.next_offset), 32'(got.next_offset));
		field_check("read_data", want.read_data, got.read_data);
	endfunction

	function automatic int outstanding();
		return awaited.size();
	endfunction
endclass

module flash_record_log_store_top_tb;

	localparam int unsigned TIMEOUT_CYCLES = 40_000_000;
	localparam int          RANDOM_ITEMS   = 850;
	localparam int          NAME_POOL      = 12;
	localparam logic [2:0]  REQ_UNUSED_A   = 3'd6;
	localparam logic [2:0]  REQ_UNUSED_B   = 3'd7;

	typedef struct {
		logic [NAME_BITS-1:0] name;
		int unsigned          index;
	} log_entry_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic done;
	rsp_t rsp;

	record_log_scoreboard sb;
	rsp_t                 last_pred;
	log_entry_t           log_entries [$];
	int unsigned          log_end;
	int                   issued;
	bit                   steady;
	int unsigned          cycle_count = 0;

	flash_record_log_store_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	always #1 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= TIMEOUT_CYCLES) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Check every result strobe
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1)
			sb.check_result(rsp);
	end

	// Mostly short gaps, a few long ones, none during a steady stretch
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 60)
			return 0;
		if (roll < 94)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Draw mostly from a small pool of names so that finds and erases hit
	function automatic logic [NAME_BITS-1:0] pick_name();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 85)
			return NAME_BITS'($urandom_range(1, NAME_POOL));
		if (roll < 95)
			return NAME_BITS'($urandom_range(1, int'(NMAX) - 1));
		return (roll < 97) ? NAME_BITS'(1) : NMAX - NAME_BITS'(1);
	endfunction

	// Fill every field with noise; the caller sets the ones that matter
	function automatic req_t scrambled(logic [2:0] op);
		req_t r;
		r.req_type     = op;
		r.name         = NAME_BITS'($urandom);
		r.start_offset = 13'($urandom);
		r.length       = 12'($urandom);
		r.data_word    = $urandom;
		r.word_index   = 12'($urandom);
		return r;
	endfunction

	function automatic int unsigned known_index();
		return log_entries[$urandom_range(0, log_entries.size() - 1)].index;
	endfunction

	// Drive one transaction and wait until it is taken
	task automatic issue_request(input req_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy !== 1'b0);
		last_pred = sb.note_request(r);
		issued++;
		// track record placement to steer later stimulus
		if (r.req_type == REQ_APPEND && last_pred.status == ST_OK) begin
			log_entries.push_back('{name: r.name, index: 32'(last_pred.record_index)});
			log_end = last_pred.record_index + 1 + (last_pred.size_bytes + 3) / 4;
		end
	endtask

	task automatic send(input logic [2:0] op, input logic [NAME_BITS-1:0] nm,
			input logic [12:0] so, input logic [11:0] ln, input logic [31:0] dw,
			input logic [11:0] wi);
		req_t r;
		r = '{req_type: op, name: nm, start_offset: so, length: ln, data_word: dw,
			word_index: wi};
		issue_request(r);
	endtask

	// Hold off until every outstanding transaction has answered
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	task automatic run_directed();
		// empty log: nothing to find, nothing pending
		send(REQ_FIND_LATEST, 20'd7, '0, '0, '0, '0);
		send(REQ_FIND_LATEST, 20'd0, '0, '0, '0, '0);
		send(REQ_FIND_FIRST, NMAX, 13'h1FFF, '0, '0, '0);
		send(REQ_FIND_FIRST, 20'd7, 13'd4096, '0, '0, '0);
		send(REQ_FIND_FIRST, 20'd7, 13'h1FFF, '0, '0, '0);
		send(REQ_PROGRAM, '0, '0, '0, 32'h0000_0000, '0);
		// reject an oversized length and a zero name
		send(REQ_APPEND, 20'd1, '0, LEN_MAX, '0, '0);
		send(REQ_APPEND, 20'd0, '0, 12'd4, '0, '0);
		// empty record, then a padded one programmed past its end
		send(REQ_APPEND, 20'd1, '0, 12'd0, '0, '0);
		send(REQ_PROGRAM, '0, '0, '0, 32'hFFFF_FFFF, '0);
		send(REQ_APPEND, NMAX - 20'd1, '0, 12'd5, '0, '0);
		send(REQ_PROGRAM, '0, '0, '0, 32'hFFFF_FFFF, '0);
		send(REQ_PROGRAM, '0, '0, '0, 32'h0000_0000, '0);
		send(REQ_PROGRAM, '0, '0, '0, 32'h1234_5678, '0);
		// replace a pending append with a new version
		send(REQ_APPEND, 20'd3, '0, 12'd12, '0, '0);
		send(REQ_PROGRAM, '0, '0, '0, 32'hA5A5_5A5A, '0);
		send(REQ_APPEND, 20'd3, '0, 12'd1, '0, '0);
		send(REQ_PROGRAM, '0, '0, '0, 32'h0F0F_F0F0, '0);
		// latest versus first version, then resume from the returned cursor
		send(REQ_FIND_LATEST, 20'd3, '0, '0, '0, '0);
		send(REQ_FIND_FIRST, 20'd3, 13'd0, '0, '0, '0);
		send(REQ_FIND_FIRST, 20'd3, last_pred.next_offset, '0, '0, '0);
		// erase: wrong name, the old version, last word, invalid name
		send(REQ_ERASE, 20'd3, '0, '0, '0, 12'd0);
		send(REQ_ERASE, 20'd3, '0, '0, '0, 12'd4);
		send(REQ_ERASE, 20'd3, '0, '0, '0, 12'd4095);
		send(REQ_ERASE, NMAX, '0, '0, '0, 12'd4);
		send(REQ_READ, '0, '0, '0, '0, 12'd0);
		send(REQ_READ, '0, '0, '0, '0, 12'd4095);
		send(REQ_UNUSED_A, 20'd1, '0, '0, '0, '0);
		send(REQ_UNUSED_B, 20'd1, '0, '0, '0, '0);
	endtask

	task automatic run_random();
		int   roll;
		int   words;
		int   hops;
		req_t r;
		while (issued < RANDOM_ITEMS) begin
			if ($urandom_range(0, 49) == 0)
				steady = ~steady;
			if ($urandom_range(0, 149) == 0)
				drain();
			roll = $urandom_range(0, 99);
			if (roll < 30 && log_end < 3400) begin
				// append a record, then program its data words
				r = scrambled(REQ_APPEND);
				r.name   = pick_name();
				r.length = 12'($urandom_range(0, 40));
				if (log_end < 2500 && $urandom_range(0, 24) == 0)
					r.length = 12'($urandom_range(41, 400));
				if (log_end > 2800)
					r.length = 12'($urandom_range(0, 16));
				if ($urandom_range(0, 19) == 0)
					r.length = LEN_MAX;
				issue_request(r);
				words = (int'(r.length) + 3) / 4;
				if (words > 16)
					words = 16;
				// break some sequences: stop short or program one too many
				roll = $urandom_range(0, 99);
				if (roll < 15)
					words = $urandom_range(0, words);
				else if (roll < 25)
					words = words + 1;
				repeat (words) begin
					r = scrambled(REQ_PROGRAM);
					if ($urandom_range(0, 9) == 0)
						r.data_word = $urandom & $urandom;
					issue_request(r);
				end
			end else if (roll < 50) begin
				r = scrambled(REQ_FIND_LATEST);
				r.name = pick_name();
				if ($urandom_range(0, 19) == 0)
					r.name = ($urandom_range(0, 1) == 0) ? '0 : NMAX;
				issue_request(r);
			end else if (roll < 65) begin
				r = scrambled(REQ_FIND_FIRST);
				r.name = pick_name();
				roll = $urandom_range(0, 99);
				if (roll < 50) begin
					// follow the cursor from match to match
					r.start_offset = '0;
					issue_request(r);
					hops = 0;
					while (last_pred.status == ST_OK && hops < 6) begin
						r.start_offset = last_pred.next_offset;
						issue_request(r);
						hops++;
					end
				end else begin
					if (roll < 80 && log_entries.size() > 0)
						r.start_offset = 13'(known_index());
					issue_request(r);
				end
			end else if (roll < 77) begin
				r = scrambled(REQ_ERASE);
				r.name = pick_name();
				if ($urandom_range(0, 3) != 0 && log_entries.size() > 0) begin
					hops = $urandom_range(0, log_entries.size() - 1);
					r.name       = log_entries[hops].name;
					r.word_index = 12'(log_entries[hops].index);
				end
				issue_request(r);
			end else if (roll < 89) begin
				r = scrambled(REQ_READ);
				if (roll < 83 && log_entries.size() > 0)
					r.word_index = 12'(known_index());
				issue_request(r);
			end else begin
				// noise; keep random appends from eating the flash
				r = scrambled(3'($urandom_range(0, 7)));
				if (r.req_type == REQ_APPEND)
					r.length = LEN_MAX;
				issue_request(r);
			end
		end
	endtask

	// Fill the flash with the largest records, then fit the rest exactly
	task automatic run_fill();
		req_t r;
		int   tries;
		tries = 0;
		do begin
			r = scrambled(REQ_APPEND);
			r.name   = pick_name();
			r.length = LEN_MAX - 12'd1;
			issue_request(r);
			tries++;
		end while (last_pred.status == ST_OK && tries < 8);
		if (log_end < FLASH_WORDS) begin
			r.length = 12'((FLASH_WORDS - log_end - 1) * 4);
			issue_request(r);
			repeat (2) issue_request(scrambled(REQ_PROGRAM));
		end
		// log now reaches the last word: no erased end is left
		r.length = 12'd8;
		issue_request(r);
		send(REQ_FIND_LATEST, 20'd1, '0, '0, '0, '0);
		send(REQ_FIND_FIRST, 20'hABCDE, 13'd0, '0, '0, '0);
		send(REQ_READ, '0, '0, '0, '0, 12'd4095);
		send(REQ_ERASE, log_entries[$].name, '0, '0, '0, 12'(log_entries[$].index));
	endtask

	initial begin
		sb        = new();
		arst_n    = 1'b0;
		start     = 1'b0;
		req       = '0;
		log_end   = 0;
		issued    = 0;
		steady    = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		run_directed();
		drain();
		issued = 0;
		run_random();
		drain();
		run_fill();
		drain();
		repeat (50) @(posedge clk);
		if (sb.outstanding() != 0) begin
			$error("%0d results never arrived", sb.outstanding());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
